### design/tns_pkg.sv
// tns_pkg: shared types and operation codes for the tone note sequencer.
// Used by every module of the sequencer; depends on nothing.

package tns_pkg;

  // Operation codes carried in the operation field of an input beat
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_PLAY    = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_WR_NOTE = 3'd3;
  localparam logic [2:0] OP_WR_SONG = 3'd4;

  // Input beat
  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  song_id;
    logic [7:0]  note_addr;
    logic [15:0] note_period;
    logic [7:0]  note_duration;
    logic        loop_mode;
    logic        song_valid;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [15:0] pwm_period;
    logic [14:0] pwm_compare;
    logic        playing;
    logic        retrigger_gap;
  } out_t;

  // One note memory entry
  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  duration;
  } note_t;

  // One song table entry
  typedef struct packed {
    logic [7:0] start_addr;
    logic       loop_f;
    logic       valid;
  } song_t;

  // Note memory request from the sequencer
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] addr;
    note_t      wdata;
  } note_req_t;

  // Song table write from the sequencer
  typedef struct packed {
    logic       wr_en;
    logic [2:0] sid;
    song_t      entry;
  } song_wr_t;

endpackage

### design/tns_note_ram.sv
// tns_note_ram: synchronous note memory, one port, registered read.
// Addresses beyond the depth read as the end-of-song sentinel. Uses tns_pkg.

module tns_note_ram #(
  parameter int NOTE_DEPTH = 256
) (
  input  logic               clk,
  input  tns_pkg::note_req_t req,
  output tns_pkg::note_t     rdata
);

  localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

  tns_pkg::note_t mem [NOTE_DEPTH];
  tns_pkg::note_t mem_q_r;
  logic           oob_r;
  logic           in_range;
  logic [AW-1:0]  idx;

  assign in_range = ({24'd0, req.addr} < 32'(NOTE_DEPTH));
  assign idx      = AW'(req.addr);

  // Write and read the array; flag reads past the end
  always_ff @(posedge clk) begin
    if (req.wr_en && in_range) begin
      mem[idx] <= req.wdata;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[idx];
      oob_r   <= !in_range;
    end
  end

  // Out-of-range reads give period 0, duration 0
  assign rdata = oob_r ? '0 : mem_q_r;

endmodule

### design/tns_song_tbl.sv
// tns_song_tbl: song table of start address, loop flag and valid mark.
// Held in flip-flops cleared at reset, read combinationally. Uses tns_pkg.

module tns_song_tbl #(
  parameter int SONG_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tns_pkg::song_wr_t wr,
  input  logic [2:0]        rd_sid,
  output tns_pkg::song_t    rdata
);

  localparam int SW = $clog2(SONG_COUNT);

  tns_pkg::song_t tbl_r [SONG_COUNT];
  logic           wr_in_range;
  logic           rd_in_range;

  assign wr_in_range = ({29'd0, wr.sid} < 32'(SONG_COUNT));
  assign rd_in_range = ({29'd0, rd_sid} < 32'(SONG_COUNT));

  // Clear at reset, store an entry on a song write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SONG_COUNT; i++) begin
        tbl_r[i] <= '0;
      end
    end else if (wr.wr_en && wr_in_range) begin
      tbl_r[SW'(wr.sid)] <= wr.entry;
    end
  end

  // Songs past the table read as empty
  assign rdata = rd_in_range ? tbl_r[SW'(rd_sid)] : '0;

endmodule

### design/tns_seq_ctrl.sv
// tns_seq_ctrl: operation decode and note playback state machine.
// Drives the note memory and song table; uses tns_pkg.

module tns_seq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tns_pkg::in_t       in_data,
  output logic               out_valid,
  output tns_pkg::out_t      out_data,
  output tns_pkg::note_req_t note_req,
  input  tns_pkg::note_t     note_rdata,
  output tns_pkg::song_wr_t  song_wr,
  input  tns_pkg::song_t     song_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RELOAD
  } state_t;

  state_t        state_r, state_nxt;
  logic [7:0]    ptr_r, ptr_nxt;
  logic [7:0]    head_r, head_nxt;
  logic          loop_r, loop_nxt;
  logic [7:0]    ticks_r, ticks_nxt;
  logic [15:0]   last_r, last_nxt;
  logic          active_r, active_nxt;
  logic [15:0]   drive_r, drive_nxt;
  logic          out_valid_r, out_valid_nxt;
  tns_pkg::out_t out_data_r;
  logic          gap;
  logic          accept;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Song table write straight from the input beat
  assign song_wr.wr_en            = accept && (in_data.operation == tns_pkg::OP_WR_SONG);
  assign song_wr.sid              = in_data.song_id;
  assign song_wr.entry.start_addr = in_data.note_addr;
  assign song_wr.entry.loop_f     = in_data.loop_mode;
  assign song_wr.entry.valid      = in_data.song_valid;

  // Next state, memory request and result
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    head_nxt      = head_r;
    loop_nxt      = loop_r;
    ticks_nxt     = ticks_r;
    last_nxt      = last_r;
    active_nxt    = active_r;
    drive_nxt     = drive_r;
    out_valid_nxt = 1'b0;
    gap           = 1'b0;

    note_req.wr_en        = 1'b0;
    note_req.rd_en        = 1'b0;
    note_req.addr         = ptr_r;
    note_req.wdata.period   = in_data.note_period;
    note_req.wdata.duration = in_data.note_duration;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_data.operation)
            tns_pkg::OP_TICK: begin
              if (active_r) begin
                if (ticks_r != 8'd0) begin
                  ticks_nxt = ticks_r - 8'd1;
                end else begin
                  // Fetch the note under the pointer; result follows the read
                  note_req.rd_en = 1'b1;
                  out_valid_nxt  = 1'b0;
                  state_nxt      = S_LOAD;
                end
              end
            end
            tns_pkg::OP_PLAY: begin
              if ((in_data.song_id == 3'd0) || !song_rdata.valid) begin
                active_nxt = 1'b0;
                ticks_nxt  = 8'd0;
                last_nxt   = 16'd0;
                drive_nxt  = 16'd0;
              end else begin
                head_nxt   = song_rdata.start_addr;
                loop_nxt   = song_rdata.loop_f;
                ptr_nxt    = song_rdata.start_addr;
                ticks_nxt  = 8'd0;
                last_nxt   = 16'd0;
                active_nxt = 1'b1;
              end
            end
            tns_pkg::OP_STOP: begin
              active_nxt = 1'b0;
              ticks_nxt  = 8'd0;
              last_nxt   = 16'd0;
              drive_nxt  = 16'd0;
            end
            tns_pkg::OP_WR_NOTE: begin
              note_req.wr_en = 1'b1;
              note_req.addr  = in_data.note_addr;
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD, S_RELOAD: begin
        if (note_rdata.duration == 8'd0) begin
          if ((state_r == S_LOAD) && loop_r) begin
            // Wrap to the song head and read again
            ptr_nxt        = head_r;
            note_req.rd_en = 1'b1;
            note_req.addr  = head_r;
            state_nxt      = S_RELOAD;
          end else begin
            // End of song, or a looping song that starts on the sentinel
            active_nxt    = 1'b0;
            ticks_nxt     = 8'd0;
            last_nxt      = 16'd0;
            drive_nxt     = 16'd0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          gap           = (note_rdata.period != 16'd0) && (note_rdata.period == last_r);
          last_nxt      = note_rdata.period;
          drive_nxt     = note_rdata.period;
          ticks_nxt     = note_rdata.duration - 8'd1;
          ptr_nxt       = ptr_r + 8'd1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      head_r      <= '0;
      loop_r      <= 1'b0;
      ticks_r     <= '0;
      last_r      <= '0;
      active_r    <= 1'b0;
      drive_r     <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      head_r      <= head_nxt;
      loop_r      <= loop_nxt;
      ticks_r     <= ticks_nxt;
      last_r      <= last_nxt;
      active_r    <= active_nxt;
      drive_r     <= drive_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_valid_nxt) begin
        out_data_r.pwm_period    <= drive_nxt;
        out_data_r.pwm_compare   <= drive_nxt[15:1];
        out_data_r.playing       <= active_nxt;
        out_data_r.retrigger_gap <= gap;
      end
    end
  end

endmodule

### design/tone_note_sequencer.sv
// Tone note sequencer: each operation's result is registered and strobes in the
// cycle after the accepting edge, except a tick that ends a note: it first reads
// the note memory (S_LOAD), then the song head (S_RELOAD) if the song wraps.
// busy is high only during those reads, so most beats can be taken every cycle.
// The receiver cannot stall. Synchronous active-low reset empties the song table
// and silences the output; note memory contents are unknown until written.

module tone_note_sequencer #(
  parameter int NOTE_DEPTH = 256,
  parameter int SONG_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tns_pkg::in_t  in_data,
  output logic          out_valid,
  output tns_pkg::out_t out_data
);

  tns_pkg::note_req_t note_req;
  tns_pkg::note_t     note_rdata;
  tns_pkg::song_wr_t  song_wr;
  tns_pkg::song_t     song_rdata;

  tns_seq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .note_req   (note_req),
    .note_rdata (note_rdata),
    .song_wr    (song_wr),
    .song_rdata (song_rdata)
  );

  tns_note_ram #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_note_ram (
    .clk   (clk),
    .req   (note_req),
    .rdata (note_rdata)
  );

  tns_song_tbl #(
    .SONG_COUNT (SONG_COUNT)
  ) u_song_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (song_wr),
    .rd_sid (in_data.song_id),
    .rdata  (song_rdata)
  );

endmodule

### design/tns_checker.sv
// tns_checker: port-level checks on the tone note sequencer, bound to the top.
// Uses tns_pkg for beat types and operation codes.

module tns_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input tns_pkg::in_t  in_data,
  input logic          out_valid,
  input tns_pkg::out_t out_data
);

  // A result beat is shown only once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Anything other than a tick answers in the next cycle
  a_quick_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.operation != tns_pkg::OP_TICK)) |=> out_valid)
    else $error("non-tick beat gave no result");

  // Compare value is half the period
  a_half_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pwm_compare == out_data.pwm_period[15:1]))
    else $error("compare not half of period");

  // Idle block is silent and never asks for a gap
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.playing) |->
      ((out_data.pwm_period == 16'd0) && !out_data.retrigger_gap))
    else $error("sound while not playing");

  // A gap is only flagged on a sounding note
  a_gap_sounding: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.retrigger_gap) |-> (out_data.pwm_period != 16'd0))
    else $error("gap on a rest");

endmodule

bind tone_note_sequencer tns_checker u_tns_checker (.*);

### test/tns_checker.sv
// tns_scoreboard: watches the command and result channels of the tone note sequencer,
// predicts each result beat and compares it field by field with what arrives.
// Depends on tns_pkg for the beat types and the operation codes.

module tns_scoreboard (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  tns_pkg::in_t  in_data,
  input  logic          out_valid,
  input  tns_pkg::out_t out_data,
  output int            errors,
  output int            outstanding,
  output int            checked,
  output int            gaps
);

  localparam int         NOTE_DEPTH = 256;
  localparam int         SONG_COUNT = 8;
  localparam logic [2:0] NO_SONG    = 3'd0;

  // Shadow copy of the sequencer state
  tns_pkg::note_t notes [NOTE_DEPTH];
  tns_pkg::song_t songs [SONG_COUNT];
  logic [7:0]     ptr;
  logic [7:0]     head;
  logic           loop_on;
  logic [7:0]     note_ticks;
  logic [15:0]    last_per;
  logic           running;
  logic [15:0]    cur_period;

  tns_pkg::out_t  result_q [$];

  // Silence the output and leave the song
  function automatic void go_silent();
    running    = 1'b0;
    note_ticks = 8'd0;
    last_per   = 16'd0;
    cur_period = 16'd0;
  endfunction

  // Count down the current note, or load the next one; return the retrigger flag
  function automatic logic advance_note();
    tns_pkg::note_t n;
    if (!running) return 1'b0;
    if (note_ticks != 8'd0) begin
      note_ticks = note_ticks - 8'd1;
      return 1'b0;
    end
    n = notes[ptr];
    if (n.duration == 8'd0) begin
      if (!loop_on) begin
        go_silent();
        return 1'b0;
      end
      // wrap to the head; a sentinel there ends the song
      ptr = head;
      n   = notes[ptr];
      if (n.duration == 8'd0) begin
        go_silent();
        return 1'b0;
      end
    end
    advance_note = (n.period != 16'd0) && (n.period == last_per);
    last_per     = n.period;
    cur_period   = n.period;
    note_ticks   = n.duration - 8'd1;
    ptr          = ptr + 8'd1;
  endfunction

  // Apply one command beat to the shadow state and form its result
  function automatic tns_pkg::out_t sequencer_result(tns_pkg::in_t b);
    tns_pkg::out_t  r;
    tns_pkg::song_t s;
    logic           gap;
    gap = 1'b0;
    s   = songs[b.song_id];
    case (b.operation)
      tns_pkg::OP_TICK: gap = advance_note();
      tns_pkg::OP_PLAY: begin
        if (b.song_id == NO_SONG || !s.valid) begin
          go_silent();
        end else begin
          head       = s.start_addr;
          loop_on    = s.loop_f;
          ptr        = s.start_addr;
          note_ticks = 8'd0;
          last_per   = 16'd0;
          running    = 1'b1;
        end
      end
      tns_pkg::OP_STOP:    go_silent();
      tns_pkg::OP_WR_NOTE: notes[b.note_addr] = {b.note_period, b.note_duration};
      tns_pkg::OP_WR_SONG: songs[b.song_id] = {b.note_addr, b.loop_mode, b.song_valid};
      default: ;
    endcase
    r.pwm_period    = cur_period;
    r.pwm_compare   = cur_period[15:1];
    r.playing       = running;
    r.retrigger_gap = gap;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors = errors + 1;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare the result beat first, then queue the prediction for a new command beat
  always @(posedge clk) begin : monitor
    tns_pkg::out_t want;
    if (!rst_n) begin
      for (int i = 0; i < SONG_COUNT; i++) songs[i] = '0;
      ptr        = 8'd0;
      head       = 8'd0;
      loop_on    = 1'b0;
      running    = 1'b0;
      note_ticks = 8'd0;
      last_per   = 16'd0;
      cur_period = 16'd0;
      result_q.delete();
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result beat, expected none, actual %0h", $time, out_data);
        end else begin
          want = result_q.pop_front();
          check_field("pwm_period", want.pwm_period, out_data.pwm_period);
          check_field("pwm_compare", 16'(want.pwm_compare), 16'(out_data.pwm_compare));
          check_field("playing", 16'(want.playing), 16'(out_data.playing));
          check_field("retrigger_gap", 16'(want.retrigger_gap),
                      16'(out_data.retrigger_gap));
          checked = checked + 1;
          if (want.retrigger_gap) gaps = gaps + 1;
        end
      end
      if (start && !busy) result_q.push_back(sequencer_result(in_data));
    end
    outstanding = result_q.size();
  end

endmodule

### test/testbench.sv
// testbench: drives command beats into the tone note sequencer and gives the verdict.
// Depends on tns_pkg, tone_note_sequencer and tns_scoreboard.

module testbench;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [2:0] NO_SONG        = 3'd0;
  localparam int         PHASE_BEATS    = 410;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  tns_pkg::in_t  in_data;
  logic          out_valid;
  tns_pkg::out_t out_data;
  int            errors;
  int            outstanding;
  int            checked;
  int            gaps;
  int            sent;
  int            idle_pct;
  int            idle_plan [4] = '{0, 51, 0, 9};

  tone_note_sequencer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  tns_scoreboard u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .errors     (errors),
    .outstanding(outstanding),
    .checked    (checked),
    .gaps       (gaps)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Command beat with every field random apart from the operation
  function automatic tns_pkg::in_t rand_beat(logic [2:0] op);
    logic [63:0]  raw;
    tns_pkg::in_t b;
    raw         = {$urandom, $urandom};
    b           = raw[$bits(tns_pkg::in_t)-1:0];
    b.operation = op;
    return b;
  endfunction

  function automatic tns_pkg::in_t beat(logic [2:0] op, logic [2:0] sid, logic [7:0] addr,
                                        logic [15:0] per, logic [7:0] dur, logic lp,
                                        logic vd);
    tns_pkg::in_t b;
    b.operation     = op;
    b.song_id       = sid;
    b.note_addr     = addr;
    b.note_period   = per;
    b.note_duration = dur;
    b.loop_mode     = lp;
    b.song_valid    = vd;
    return b;
  endfunction

  // Mostly short notes, now and then any length including the sentinel
  function automatic logic [7:0] pick_duration();
    if ($urandom_range(63) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(3, 1));
  endfunction

  // Mostly ticks, with stops, spare codes, stray writes and plays mixed in
  function automatic tns_pkg::in_t tick_or_noise();
    int r;
    r = $urandom_range(99);
    if (r < 88) return rand_beat(tns_pkg::OP_TICK);
    if (r < 91) return rand_beat(tns_pkg::OP_STOP);
    if (r < 94) return rand_beat(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)));
    if (r < 96) return rand_beat(tns_pkg::OP_WR_NOTE);
    if (r < 98) return rand_beat(tns_pkg::OP_WR_SONG);
    return rand_beat(tns_pkg::OP_PLAY);
  endfunction

  // Offer one beat after a random idle spell and hold it until taken
  task automatic send(tns_pkg::in_t b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= rand_beat(3'($urandom_range(OP_SPARE_LAST)));
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    sent = sent + 1;
  endtask

  // Only addresses 0 to 3 and 255 are read before the note memory is filled
  task automatic run_directed();
    send(beat(tns_pkg::OP_TICK, 3'h7, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
    send(beat(tns_pkg::OP_STOP, NO_SONG, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    send(beat(tns_pkg::OP_PLAY, NO_SONG, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    send(beat(tns_pkg::OP_WR_NOTE, 3'd0, 8'd0, 16'hFFFF, 8'd2, 1'b0, 1'b0));
    send(beat(tns_pkg::OP_WR_NOTE, 3'd0, 8'd1, 16'hFFFF, 8'd1, 1'b0, 1'b0));
    send(beat(tns_pkg::OP_WR_NOTE, 3'd0, 8'd2, 16'h0000, 8'd1, 1'b0, 1'b0));
    send(beat(tns_pkg::OP_WR_NOTE, 3'd0, 8'd3, 16'h0001, 8'd0, 1'b0, 1'b0));
    send(beat(tns_pkg::OP_WR_NOTE, 3'd0, 8'd255, 16'h0001, 8'd1, 1'b0, 1'b0));
    send(beat(tns_pkg::OP_WR_NOTE, 3'd0, 8'd250, 16'hAAAA, 8'd255, 1'b0, 1'b0));
    send(beat(tns_pkg::OP_WR_SONG, 3'd1, 8'd0, 16'h0000, 8'h00, 1'b1, 1'b1));
    send(beat(tns_pkg::OP_WR_SONG, 3'd7, 8'd3, 16'h0000, 8'h00, 1'b1, 1'b1));
    send(beat(tns_pkg::OP_WR_SONG, 3'd6, 8'd255, 16'h0000, 8'h00, 1'b0, 1'b1));
    send(beat(tns_pkg::OP_WR_SONG, 3'd5, 8'd0, 16'h0000, 8'h00, 1'b1, 1'b0));
    // invalid song acts as stop
    send(beat(tns_pkg::OP_PLAY, 3'd5, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    // looping song: long note, repeated pitch, rest, sentinel back to the head
    send(beat(tns_pkg::OP_PLAY, 3'd1, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    repeat (5) send(rand_beat(tns_pkg::OP_TICK));
    send(rand_beat(OP_SPARE_FIRST));
    // looping song whose head is the sentinel stops
    send(beat(tns_pkg::OP_PLAY, 3'd7, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    send(rand_beat(tns_pkg::OP_TICK));
    // pointer wraps from the top address to zero
    send(beat(tns_pkg::OP_PLAY, 3'd6, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    repeat (3) send(rand_beat(tns_pkg::OP_TICK));
    send(beat(tns_pkg::OP_WR_SONG, NO_SONG, 8'd7, 16'h0000, 8'h00, 1'b0, 1'b1));
    send(beat(OP_SPARE_LAST, 3'h7, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
    send(beat(tns_pkg::OP_PLAY, NO_SONG, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
  endtask

  // Write every note entry so that any later read finds known contents
  task automatic fill_notes();
    tns_pkg::in_t b;
    for (int a = 0; a < 256; a++) begin
      b               = rand_beat(tns_pkg::OP_WR_NOTE);
      b.note_addr     = 8'(a);
      b.note_period   = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
      b.note_duration = ($urandom_range(3) == 0) ? 8'd0 : pick_duration();
      send(b);
    end
  endtask

  // Write a short melody and its song entry, play it and tick through it
  task automatic play_melody();
    tns_pkg::in_t b;
    logic [7:0]   base;
    logic [15:0]  per;
    logic [2:0]   sid;
    int           len;
    base = 8'($urandom_range(255));
    len  = $urandom_range(5, 1);
    per  = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      // rests, repeated pitches and fresh pitches
      case ($urandom_range(3))
        0: per = 16'd0;
        1: ;
        default: per = 16'($urandom);
      endcase
      b               = rand_beat(tns_pkg::OP_WR_NOTE);
      b.note_addr     = 8'(base + i);
      b.note_period   = per;
      b.note_duration = pick_duration();
      send(b);
    end
    b               = rand_beat(tns_pkg::OP_WR_NOTE);
    b.note_addr     = 8'(base + len);
    b.note_duration = 8'd0;
    send(b);
    sid          = ($urandom_range(15) == 0) ? NO_SONG : 3'($urandom_range(7, 1));
    b            = rand_beat(tns_pkg::OP_WR_SONG);
    b.song_id    = sid;
    b.note_addr  = base;
    b.song_valid = ($urandom_range(9) != 0);
    send(b);
    b         = rand_beat(tns_pkg::OP_PLAY);
    b.song_id = ($urandom_range(19) == 0) ? 3'($urandom) : sid;
    send(b);
    repeat ($urandom_range(30, 4)) send(tick_or_noise());
  endtask

  initial begin
    int phase_end;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    idle_pct = 0;
    sent     = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    fill_notes();
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      phase_end = sent + PHASE_BEATS;
      while (sent < phase_end) play_melody();
    end
    @(negedge clk);
    start <= 1'b0;

    // drain the result channel, then give stray beats a chance to show
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Drove %0d command beats: directed cases, a full note fill, melodies under",
             sent);
    $display("four idle patterns; checked %0d results, %0d with a retrigger gap",
             checked, gaps);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
